// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, guarded by a disable condition
`define ASSERT_IMPLIES(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, guarded by a disable condition
`define ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cppm_pkg.sv -----
// ----------------------------------------------------------------------------
// cppm_pkg
// Shared types and constants of the circle pixel position mapper.
// ----------------------------------------------------------------------------
package cppm_pkg;

  typedef enum logic [2:0] {
    REG_PIXEL_COUNT   = 3'd0,
    REG_CENTER_X      = 3'd1,
    REG_CENTER_Y      = 3'd2,
    REG_CENTER_Z      = 3'd3,
    REG_CIRCLE_RADIUS = 3'd4,
    REG_START_ANGLE   = 3'd5
  } reg_index_t;

  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int NUM_W     = IDX_W + 16;
  localparam int PHASE_W   = 16;
  localparam int ROT_W     = 18;
  localparam int TRIG_W    = 17;
  localparam int ROT_CELLS = 14;

  localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 18'sd19899;

  localparam logic signed [ROT_W-1:0] ATAN_TURN16 [ROT_CELLS] = '{
    18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163,
    18'sd81, 18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1
  };

  // word travelling down the divider row
  typedef struct packed {
    logic               valid;
    logic [CNT_W-1:0]   rem;
    logic [NUM_W-1:0]   num;
    logic [PHASE_W-1:0] quo;
  } div_word_t;

  // word travelling down the rotation row
  typedef struct packed {
    logic                    valid;
    logic                    neg;
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] t;
  } rot_word_t;

endpackage

// ----- rtl/circle_pixel_position_mapper.sv -----
// ----------------------------------------------------------------------------
// circle_pixel_position_mapper
// Places a pixel on a circle: phase by division, cos/sin by CORDIC cells,
// then scale by the radius, offset by the centre and normalise.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  input    | in_valid / in_ready   | pixel_index
//  result   | out_valid / out_ready | pos_x, pos_y, pos_z, norm_x, norm_y
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One word per clock while the skid register is empty. Stages: 26 divider
//  cells, one fold stage, 14 rotation cells, three output stages.
//  The divider row sets the latency: one quotient bit per cell.
//  rst (synchronous) empties every stage and loads register reset values.
//  A stalled result drops into a skid register; input is refused only while
//  the skid register holds a word.
// ----------------------------------------------------------------------------
module circle_pixel_position_mapper #(
  parameter int  MAX_PIXELS  = 1024,
  parameter int  COORD_WIDTH = 16,
  localparam int CFG_W       = (COORD_WIDTH > 16) ? COORD_WIDTH : 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cppm_pkg::IDX_W-1:0]  pixel_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COORD_WIDTH-1:0] pos_x,
  output logic signed [COORD_WIDTH-1:0] pos_y,
  output logic signed [COORD_WIDTH-1:0] pos_z,
  output logic [15:0]                 norm_x,
  output logic [15:0]                 norm_y,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [CFG_W-1:0]            cfg_data
);
  import cppm_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int PROD_W = W + TRIG_W;
  localparam int SUM_W  = W + 4;
  localparam logic [CNT_W-1:0] CNT_CAP =
    CNT_W'((MAX_PIXELS > 2047) ? 2047 : MAX_PIXELS);
  localparam logic [CNT_W-1:0] CNT_RST = (CNT_CAP < 11'd32) ? CNT_CAP : 11'd32;
  // reciprocal of 2250 scaled by 2^40 for the start angle offset
  localparam logic [28:0] RECIP = 29'((64'd1 << 40) / 64'd2250);

  // ---------------------------------------------------------------- config
  logic [CNT_W-1:0]    pix_cnt;
  logic signed [W-1:0] center_x;
  logic signed [W-1:0] center_y;
  logic signed [W-1:0] center_z;
  logic [W-2:0]        radius;
  logic [15:0]         start_angle;
  logic [CNT_W-1:0]    cnt_wr;

  assign cfg_ready = 1'b1;

  // hold the count already clamped to 1..CNT_CAP
  always_comb begin
    cnt_wr = cfg_data[CNT_W-1:0];
    if (cnt_wr == '0) begin
      cnt_wr = CNT_W'(1);
    end else if (cnt_wr > CNT_CAP) begin
      cnt_wr = CNT_CAP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_cnt     <= CNT_RST;
      center_x    <= '0;
      center_y    <= '0;
      center_z    <= '0;
      radius      <= (W-1)'(128);
      start_angle <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PIXEL_COUNT:   pix_cnt     <= cnt_wr;
        REG_CENTER_X:      center_x    <= cfg_data[W-1:0];
        REG_CENTER_Y:      center_y    <= cfg_data[W-1:0];
        REG_CENTER_Z:      center_z    <= cfg_data[W-1:0];
        REG_CIRCLE_RADIUS: radius      <= cfg_data[W-2:0];
        REG_START_ANGLE:   start_angle <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------- start angle offset
  // round(sa * 65536 / 36000) = floor((sa * 4096 + 1125) / 2250).
  // Free-running; settles well before any word needs it.
  logic [27:0]        off_m;
  logic [56:0]        off_p;
  logic [16:0]        off_q0;
  logic [16:0]        off_q1;
  logic [28:0]        off_qm;
  logic [27:0]        off_r;
  logic [PHASE_W-1:0] offset;

  assign off_m = {start_angle, 12'd0} + 28'd1125;
  assign off_r = off_m - off_qm[27:0];

  always_ff @(posedge clk) begin
    off_p  <= off_m * RECIP;
    off_q0 <= off_p[56:40];
    off_q1 <= off_q0;
    off_qm <= 29'(off_q0 * 29'd2250);
    offset <= (off_r >= 28'd2250) ? PHASE_W'(off_q1 + 17'd1) : off_q1[PHASE_W-1:0];
  end

  // ------------------------------------------------------ stall control
  logic en;
  logic sk_valid;

  assign en       = !sk_valid;
  assign in_ready = en;

  // -------------------------------------------------------- divider row
  div_word_t dw [NUM_W+1];

  always_comb begin
    dw[0].valid = in_valid;
    dw[0].rem   = '0;
    dw[0].num   = {pixel_index, 16'd0};
    dw[0].quo   = '0;
  end

  for (genvar g = 0; g < NUM_W; g++) begin : g_div
    cppm_div_cell u_div (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .divisor (pix_cnt),
      .din     (dw[g]),
      .dout    (dw[g+1])
    );
  end

  // ---------------------------------------------- phase add and quadrant fold
  logic [PHASE_W-1:0]      phase;
  logic signed [ROT_W-1:0] t_raw;
  rot_word_t               fold_next;
  rot_word_t               rw [ROT_CELLS+1];

  assign phase = dw[NUM_W].quo + offset;
  assign t_raw = {{(ROT_W-PHASE_W){phase[PHASE_W-1]}}, phase};

  always_comb begin
    fold_next.valid = dw[NUM_W].valid;
    fold_next.x     = CORDIC_GAIN;
    fold_next.y     = '0;
    fold_next.neg   = 1'b0;
    fold_next.t     = t_raw;
    if (t_raw > 18'sd16384) begin
      fold_next.t   = t_raw - 18'sd32768;
      fold_next.neg = 1'b1;
    end else if (t_raw < -18'sd16384) begin
      fold_next.t   = t_raw + 18'sd32768;
      fold_next.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rw[0] <= '0;
    end else if (en) begin
      rw[0] <= fold_next;
    end
  end

  // ------------------------------------------------------- rotation row
  for (genvar g = 0; g < ROT_CELLS; g++) begin : g_rot
    cppm_rot_cell #(.STAGE(g)) u_rot (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (rw[g]),
      .dout (rw[g+1])
    );
  end

  // ------------------------------------------------------- output stages
  function automatic logic signed [TRIG_W-1:0] trig_clamp(
    input logic signed [ROT_W-1:0] v,
    input logic                    neg
  );
    logic signed [ROT_W-1:0] w;
    w = neg ? -v : v;
    if (w > 18'sd32768) begin
      return 17'sd32768 - 17'sd1 + 17'sd1;
    end else if (w < -18'sd32768) begin
      return -17'sd32768;
    end
    return w[TRIG_W-1:0];
  endfunction

  function automatic logic [15:0] norm_of(input logic signed [TRIG_W-1:0] v);
    logic signed [ROT_W-1:0] s;
    s = {v[TRIG_W-1], v} + 18'sd32768;
    return (s > 18'sd65535) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic signed [W-1:0] place(
    input logic signed [W-1:0]      c,
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W:0]  pr;
    logic signed [SUM_W-1:0] v;
    pr = {p[PROD_W-1], p} + (PROD_W+1)'(16384);
    v  = {{(SUM_W-W){c[W-1]}}, c} + SUM_W'(pr >>> 15);
    if (v > SUM_W'((1 <<< (W-1)) - 1)) begin
      return {1'b0, {(W-1){1'b1}}};
    end else if (v < -(SUM_W'(1) <<< (W-1))) begin
      return {1'b1, {(W-1){1'b0}}};
    end
    return v[W-1:0];
  endfunction

  // stage A: undo the fold and clamp
  logic                     a_valid;
  logic signed [TRIG_W-1:0] a_cos;
  logic signed [TRIG_W-1:0] a_sin;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= rw[ROT_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_cos <= trig_clamp(rw[ROT_CELLS].x, rw[ROT_CELLS].neg);
      a_sin <= trig_clamp(rw[ROT_CELLS].y, rw[ROT_CELLS].neg);
    end
  end

  // stage B: scale by the radius
  logic                     b_valid;
  logic signed [TRIG_W-1:0] b_cos;
  logic signed [TRIG_W-1:0] b_sin;
  logic signed [PROD_W-1:0] b_px;
  logic signed [PROD_W-1:0] b_py;
  logic signed [W-1:0]      rad_s;

  assign rad_s = {1'b0, radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_cos <= a_cos;
      b_sin <= a_sin;
      b_px  <= rad_s * a_cos;
      b_py  <= rad_s * a_sin;
    end
  end

  // stage C: round, add the centre, saturate, normalise
  logic                c_valid;
  logic signed [W-1:0] c_px;
  logic signed [W-1:0] c_py;
  logic [15:0]         c_nx;
  logic [15:0]         c_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_px <= place(center_x, b_px);
      c_py <= place(center_y, b_py);
      c_nx <= (radius == '0) ? 16'h8000 : norm_of(b_cos);
      c_ny <= (radius == '0) ? 16'h8000 : norm_of(b_sin);
    end
  end

  // ------------------------------------------------------- skid register
  logic signed [W-1:0] sk_px;
  logic signed [W-1:0] sk_py;
  logic [15:0]         sk_nx;
  logic [15:0]         sk_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      sk_valid <= 1'b0;
    end else if (sk_valid) begin
      if (out_ready) begin
        sk_valid <= 1'b0;
      end
    end else if (c_valid && !out_ready) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_valid) begin
      sk_px <= c_px;
      sk_py <= c_py;
      sk_nx <= c_nx;
      sk_ny <= c_ny;
    end
  end

  assign out_valid = sk_valid || c_valid;
  assign pos_x     = sk_valid ? sk_px : c_px;
  assign pos_y     = sk_valid ? sk_py : c_py;
  assign norm_x    = sk_valid ? sk_nx : c_nx;
  assign norm_y    = sk_valid ? sk_ny : c_ny;
  assign pos_z     = center_z;

endmodule

// ----- rtl/cppm_div_cell.sv -----
// ----------------------------------------------------------------------------
// cppm_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module cppm_div_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [cppm_pkg::CNT_W-1:0] divisor,
  input  cppm_pkg::div_word_t        din,
  output cppm_pkg::div_word_t        dout
);
  import cppm_pkg::*;

  logic [CNT_W:0]   trial;
  logic             take;
  div_word_t        dout_next;

  always_comb begin
    trial = {din.rem, din.num[NUM_W-1]};
    take  = (trial >= {1'b0, divisor});
    dout_next.valid = din.valid;
    dout_next.rem   = take ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
    dout_next.num   = {din.num[NUM_W-2:0], 1'b0};
    dout_next.quo   = {din.quo[PHASE_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

// ----- rtl/cppm_rot_cell.sv -----
// ----------------------------------------------------------------------------
// cppm_rot_cell
// One CORDIC micro-rotation with a fixed shift and arctangent step.
// ----------------------------------------------------------------------------
module cppm_rot_cell #(
  parameter int STAGE = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  cppm_pkg::rot_word_t din,
  output cppm_pkg::rot_word_t dout
);
  import cppm_pkg::*;

  logic signed [ROT_W-1:0] dx;
  logic signed [ROT_W-1:0] dy;
  rot_word_t               dout_next;

  always_comb begin
    dx = din.y >>> STAGE;
    dy = din.x >>> STAGE;
    dout_next       = din;
    if (!din.t[ROT_W-1]) begin
      dout_next.x = din.x - dx;
      dout_next.y = din.y + dy;
      dout_next.t = din.t - ATAN_TURN16[STAGE];
    end else begin
      dout_next.x = din.x + dx;
      dout_next.y = din.y - dy;
      dout_next.t = din.t + ATAN_TURN16[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

// ----- rtl/cppm_checker.sv -----
// ----------------------------------------------------------------------------
// cppm_checker
// Port-level assertions for the circle pixel position mapper.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cppm_checker #(
  parameter int COORD_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [COORD_WIDTH-1:0] pos_x,
  input logic [15:0]            norm_x
);

  // a stalled result holds its word
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(pos_x) && $stable(norm_x), "stalled result changed")

  // input is refused only while a result waits
  `ASSERT_IMPLIES(a_stall_cause, clk, rst, !in_ready, out_valid, "input refused with no result waiting")

  // reset empties the pipeline
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid, "result shown straight after reset")

  // configuration writes never stall
  `ASSERT_IMPLIES(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind circle_pixel_position_mapper cppm_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cppm_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circle pixel position mapper testbench
// Drives pixel indices through the mapper under several register settings,
// predicts each position with a bit-true CORDIC model and compares every
// result word, in order, against the prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import cppm_pkg::*;

  localparam int LATENCY   = 45;
  localparam int CYC_LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic [15:0]        nx;
    logic [15:0]        ny;
  } place_t;

  // Scoreboard: holds expected positions and checks result words against them
  class position_board;
    place_t      pending[$];
    int          mismatches;
    logic [10:0] count_r;
    logic signed [15:0] cx_r, cy_r, cz_r;
    logic [14:0] radius_r;
    logic [15:0] angle_r;

    function new();
      mismatches = 0;
      count_r = 11'd32; cx_r = 0; cy_r = 0; cz_r = 0;
      radius_r = 15'd128; angle_r = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [15:0] d);
      case (idx)
        REG_PIXEL_COUNT:   count_r = d[10:0];
        REG_CENTER_X:      cx_r = d;
        REG_CENTER_Y:      cy_r = d;
        REG_CENTER_Z:      cz_r = d;
        REG_CIRCLE_RADIUS: radius_r = d[14:0];
        REG_START_ANGLE:   angle_r = d;
        default: ;
      endcase
    endfunction

    function longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function logic signed [15:0] scale(longint ctr, longint trig);
      longint prod;
      prod = longint'(radius_r) * trig;
      return 16'(clampl(ctr + ((prod + 16384) >>> 15), -32768, 32767));
    endfunction

    function void note_index(logic [9:0] idx);
      longint cnt, ph, t, x, y, dx, dy;
      bit neg;
      place_t e;
      cnt = count_r;
      neg = 0;
      if (cnt == 0) cnt = 1;
      if (cnt > 1024) cnt = 1024;
      ph = ((longint'(idx) << 16) / cnt + ((longint'(angle_r) << 16) + 18000) / 36000)
           & 16'hFFFF;
      t = ph;
      if (t >= 32768) t -= 65536;
      if (t > 16384) begin
        t -= 32768; neg = 1;
      end else if (t < -16384) begin
        t += 32768; neg = 1;
      end
      x = 19899; y = 0;
      for (int i = 0; i < ROT_CELLS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (t >= 0) begin
          x -= dx; y += dy; t -= ATAN_TURN16[i];
        end else begin
          x += dx; y -= dy; t += ATAN_TURN16[i];
        end
      end
      if (neg) begin
        x = -x; y = -y;
      end
      x = clampl(x, -32768, 32768);
      y = clampl(y, -32768, 32768);
      e.px = scale(cx_r, x);
      e.py = scale(cy_r, y);
      e.pz = cz_r;
      e.nx = (radius_r == 0) ? 16'd32768 : 16'(clampl(x + 32768, 0, 65535));
      e.ny = (radius_r == 0) ? 16'd32768 : 16'(clampl(y + 32768, 0, 65535));
      pending.push_back(e);
    endfunction

    function void check_word(place_t got);
      place_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      e = pending.pop_front();
      if (e.px !== got.px || e.py !== got.py || e.pz !== got.pz ||
          e.nx !== got.nx || e.ny !== got.ny) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp x=%0d y=%0d z=%0d nx=%0d ny=%0d got x=%0d y=%0d z=%0d nx=%0d ny=%0d",
                   e.px, e.py, e.pz, e.nx, e.ny,
                   got.px, got.py, got.pz, got.nx, got.ny);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic [9:0] pixel_index = 0;
  logic out_valid, out_ready = 0;
  logic signed [15:0] pos_x, pos_y, pos_z;
  logic [15:0] norm_x, norm_y;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  position_board board = new();
  bit calm;      // no idling in the closing stretch
  bit sink_open; // declared but never used; calm governs result stalls
  int cycles;

  circle_pixel_position_mapper DUT (.*);

  always #5 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: check each accepted word, stall in random bursts
  int stall_left;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_word({pos_x, pos_y, pos_z, norm_x, norm_y});
    if (rst) begin
      out_ready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 16) - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // Write one register and advance the shadow copy; valid is left high so
  // that writes run back to back, the caller drops it
  task automatic write_cfg(reg_index_t idx, logic [15:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, d);
  endtask

  // Send one pixel index, with an optional random gap first; valid is left
  // high so that words run back to back
  task automatic send_index(logic [9:0] idx);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid    <= 1;
    pixel_index <= idx;
    do @(posedge clk); while (!in_ready);
    board.note_index(idx);
  endtask

  // Drop valid, wait until every expected word has arrived, then let the
  // pipe settle
  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] cnt, logic [15:0] x, logic [15:0] y,
                         logic [15:0] z, logic [15:0] r, logic [15:0] a);
    write_cfg(REG_PIXEL_COUNT, cnt);
    write_cfg(REG_CENTER_X, x);
    write_cfg(REG_CENTER_Y, y);
    write_cfg(REG_CENTER_Z, z);
    write_cfg(REG_CIRCLE_RADIUS, r);
    write_cfg(REG_START_ANGLE, a);
    cfg_valid <= 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset settings, extremes of the index and full turn
    for (int b = 0; b < 10; b++) send_index(10'd1 << b);
    send_index(10'd0);
    send_index(10'd1023);
    for (int i = 0; i < 8; i++) send_index(10'(i * 4));
    drain();
    // Zero radius, zero count, saturating centre and radius, wrapping angle
    set_all(16'd0, 16'h7FFF, 16'h8000, 16'h8000, 16'd0, 16'hFFFF);
    send_index(10'd0); send_index(10'd1023);
    drain();
    set_all(16'h7FF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd36000);
    for (int i = 0; i < 6; i++) send_index(10'($urandom_range(0, 1023)));
    drain();
    write_cfg(reg_index_t'(3'd7), 16'h1234); // unknown index, ignored

    // Random phases, each under fresh settings
    for (int ph = 0; ph < 8; ph++) begin
      set_all(16'($urandom_range(0, 2047)), 16'($urandom), 16'($urandom),
              16'($urandom), (ph == 1) ? 16'd0 : 16'($urandom),
              16'($urandom));
      if (ph == 7) calm = 1;
      for (int i = 0; i < 100; i++) send_index(10'($urandom_range(0, 1023)));
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cppm_pkg.sv
rtl/cppm_div_cell.sv
rtl/cppm_rot_cell.sv
rtl/circle_pixel_position_mapper.sv
rtl/cppm_checker.sv
sim/tb_top.sv
